### hdl/qflc_pkg.sv
// Shared types, codes and request tables of the query frame link controller.
package qflc_pkg;

    localparam int HEADER_LEN = 7;
    localparam int COUNT_W    = 5;

    // Event codes carried in the action field.
    localparam logic [2:0] ACT_START  = 3'd0;
    localparam logic [2:0] ACT_CANCEL = 3'd1;
    localparam logic [2:0] ACT_TICK   = 3'd2;
    localparam logic [2:0] ACT_TX     = 3'd3;
    localparam logic [2:0] ACT_RX     = 3'd4;
    localparam logic [2:0] ACT_IOERR  = 3'd5;

    // Link phase codes.
    localparam logic [2:0] PH_IDLE    = 3'd0;
    localparam logic [2:0] PH_RUNNING = 3'd1;
    localparam logic [2:0] PH_SUCCESS = 3'd2;
    localparam logic [2:0] PH_TIMEOUT = 3'd3;
    localparam logic [2:0] PH_IOERR   = 3'd4;
    localparam logic [2:0] PH_CANCEL  = 3'd5;

    localparam logic QUERY_VERSION = 1'b0;
    localparam logic QUERY_DETECT  = 1'b1;

    localparam logic [31:0] TIMEOUT_RESET = 32'd1000;

    typedef struct packed {
        logic [2:0]  action;
        logic [31:0] now_ms;
        logic        query_kind;
        logic [7:0]  rx_byte;
    } in_item_t;

    typedef struct packed {
        logic        start_accepted;
        logic        tx_valid;
        logic [7:0]  tx_byte;
        logic [2:0]  phase;
        logic [23:0] reply_value;
        logic [31:0] frames_received;
        logic [31:0] frames_rejected;
        logic [31:0] start_count;
    } out_item_t;

    typedef logic [HEADER_LEN-1:0][7:0] header_t;

    typedef struct packed {
        logic        hit;
        logic [23:0] reply;
    } match_t;

    // Fixed four-byte request of each query.
    function automatic logic [7:0] request_byte(input logic sel, input logic [1:0] idx);
        logic [7:0] b;
        b = 8'h00;
        if (sel == QUERY_VERSION)
        begin
            case (idx)
                2'd0:    b = 8'hbc;
                2'd1:    b = 8'h04;
                2'd2:    b = 8'he1;
                default: b = 8'h02;
            endcase
        end
        else
        begin
            case (idx)
                2'd0:    b = 8'hbc;
                2'd1:    b = 8'h03;
                2'd2:    b = 8'h87;
                default: b = 8'h00;
            endcase
        end
        return b;
    endfunction

endpackage

### hdl/qflc_ifs.sv
// Valid/ready channel interfaces of the query frame link controller.
interface qflc_item_if;
    import qflc_pkg::*;
    logic     valid;
    logic     ready;
    in_item_t payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface qflc_result_if;
    import qflc_pkg::*;
    logic      valid;
    logic      ready;
    out_item_t payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface qflc_cfg_if;
    logic        valid;
    logic        ready;
    logic [31:0] data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

### hdl/qflc_frame_check.sv
// Header match of a completed reply frame against the running query.
module qflc_frame_check (
    input  logic             query_sel,
    input  qflc_pkg::header_t header,
    output qflc_pkg::match_t  result
);
    import qflc_pkg::*;

    logic version_hit;
    logic detect_hit;

    always_comb
    begin
        version_hit = (header[0] == 8'hcb) && (header[1] == 8'h07) &&
                      (header[2] == 8'he1) && (header[3] == 8'h03);
        detect_hit  = (header[0] == 8'hcb) && (header[1] == 8'h04) &&
                      (header[2] == 8'h87) && (header[3] <= 8'd3) &&
                      (header[4] == 8'h00) && (header[5] == 8'h00) &&
                      (header[6] == 8'h00);
        if (query_sel == QUERY_VERSION)
        begin
            result.hit   = version_hit;
            result.reply = {header[6], header[5], header[4]};
        end
        else
        begin
            result.hit   = detect_hit;
            result.reply = {16'h0000, header[3]};
        end
    end

endmodule

### hdl/query_frame_link_controller.sv
// Top level of the query frame link controller.
//
// Events arrive as beats on the item channel; each beat gives exactly one beat
// on the result channel, carrying the link status after that event. The
// timeout register is written through the cfg channel, which is always ready;
// write it only while no result is outstanding.
//
// The event is decoded and the state updated at the edge that accepts it, and
// the result is held in an output register. Throughput is one event per
// cycle. The item channel stays ready while the output register is empty or
// is being drained in the same cycle, so a stalled receiver holds back at
// most one result before input stalls too.
//
// Reset clears the phase to idle, all counters, the header and the reply,
// and loads the timeout with 1000 ms. FRAME_LEN sets the length of request
// and reply frames in bytes.
module query_frame_link_controller #(
    parameter int FRAME_LEN = 16
) (
    input  logic clk,
    input  logic rst_n,
    qflc_item_if.sink     item,
    qflc_result_if.source result,
    qflc_cfg_if.sink      cfg
);
    import qflc_pkg::*;

    localparam logic [COUNT_W-1:0] FRAME_END = COUNT_W'(FRAME_LEN);

    logic [31:0]        timeout_reg;
    logic [2:0]         phase_reg, phase_next;
    logic               query_sel_reg, query_sel_next;
    logic [31:0]        start_time_reg, start_time_next;
    logic [31:0]        starts_reg, starts_next;
    logic [COUNT_W-1:0] sent_reg, sent_next;
    logic [COUNT_W-1:0] pos_reg, pos_next;
    header_t            header_reg, header_next;
    logic               pad_reg, pad_next;
    logic [23:0]        reply_reg, reply_next;
    logic [31:0]        received_reg, received_next;
    logic [31:0]        rejected_reg, rejected_next;

    logic               out_valid_reg;
    out_item_t          out_reg, out_next;

    logic               accept;
    logic               running;
    header_t            header_wr;
    logic               pad_wr;
    logic [COUNT_W-1:0] pos_inc;
    logic [31:0]        elapsed;
    match_t             match;

    assign accept       = item.valid && item.ready;
    assign item.ready   = !out_valid_reg || result.ready;
    assign cfg.ready    = 1'b1;
    assign result.valid = out_valid_reg;
    assign result.payload = out_reg;

    assign running = (phase_reg == PH_RUNNING);
    assign pos_inc = pos_reg + COUNT_W'(1);
    assign elapsed = item.payload.now_ms - start_time_reg;

    // Header as it stands once the received byte is stored.
    always_comb
    begin
        header_wr = header_reg;
        for (int i = 0; i < HEADER_LEN; i++)
        begin
            if (pos_reg == COUNT_W'(i))
            begin
                header_wr[i] = item.payload.rx_byte;
            end
        end
        pad_wr = pad_reg ||
                 ((pos_reg >= COUNT_W'(HEADER_LEN)) && (item.payload.rx_byte != 8'h00));
    end

    qflc_frame_check u_check (
        .query_sel (query_sel_reg),
        .header    (header_wr),
        .result    (match)
    );

    always_comb
    begin
        phase_next      = phase_reg;
        query_sel_next  = query_sel_reg;
        start_time_next = start_time_reg;
        starts_next     = starts_reg;
        sent_next       = sent_reg;
        pos_next        = pos_reg;
        header_next     = header_reg;
        pad_next        = pad_reg;
        reply_next      = reply_reg;
        received_next   = received_reg;
        rejected_next   = rejected_reg;
        out_next.start_accepted = 1'b0;
        out_next.tx_valid       = 1'b0;
        out_next.tx_byte        = 8'h00;

        case (item.payload.action)
            ACT_START:
            begin
                if (!running)
                begin
                    query_sel_next  = item.payload.query_kind;
                    phase_next      = PH_RUNNING;
                    start_time_next = item.payload.now_ms;
                    starts_next     = starts_reg + 32'd1;
                    sent_next       = '0;
                    pos_next        = '0;
                    pad_next        = 1'b0;
                    reply_next      = '0;
                    header_next     = '0;
                    received_next   = '0;
                    rejected_next   = '0;
                    out_next.start_accepted = 1'b1;
                end
            end
            ACT_CANCEL:
            begin
                if (running)
                begin
                    phase_next = PH_CANCEL;
                end
            end
            ACT_TICK:
            begin
                if (running && (elapsed >= timeout_reg))
                begin
                    phase_next = PH_TIMEOUT;
                end
            end
            ACT_TX:
            begin
                if (running && (sent_reg < FRAME_END))
                begin
                    out_next.tx_valid = 1'b1;
                    if (sent_reg < COUNT_W'(4))
                    begin
                        out_next.tx_byte = request_byte(query_sel_reg, sent_reg[1:0]);
                    end
                    sent_next = sent_reg + COUNT_W'(1);
                end
            end
            ACT_RX:
            begin
                if (running)
                begin
                    header_next = header_wr;
                    pad_next    = pad_wr;
                    pos_next    = pos_inc;
                    if (pos_inc == FRAME_END)
                    begin
                        received_next = received_reg + 32'd1;
                        if ((sent_reg == FRAME_END) && !pad_wr && match.hit)
                        begin
                            reply_next = match.reply;
                            phase_next = PH_SUCCESS;
                        end
                        else
                        begin
                            // A bad frame is dropped and reassembly starts over.
                            rejected_next = rejected_reg + 32'd1;
                            pos_next      = '0;
                            pad_next      = 1'b0;
                        end
                    end
                end
            end
            ACT_IOERR:
            begin
                if (running)
                begin
                    phase_next = PH_IOERR;
                end
            end
            default:
            begin
            end
        endcase

        out_next.phase           = phase_next;
        out_next.reply_value     = reply_next;
        out_next.frames_received = received_next;
        out_next.frames_rejected = rejected_next;
        out_next.start_count     = starts_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg    <= TIMEOUT_RESET;
            phase_reg      <= PH_IDLE;
            query_sel_reg  <= QUERY_VERSION;
            start_time_reg <= '0;
            starts_reg     <= '0;
            sent_reg       <= '0;
            pos_reg        <= '0;
            header_reg     <= '0;
            pad_reg        <= 1'b0;
            reply_reg      <= '0;
            received_reg   <= '0;
            rejected_reg   <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
            begin
                timeout_reg <= cfg.data;
            end
            if (accept)
            begin
                phase_reg      <= phase_next;
                query_sel_reg  <= query_sel_next;
                start_time_reg <= start_time_next;
                starts_reg     <= starts_next;
                sent_reg       <= sent_next;
                pos_reg        <= pos_next;
                header_reg     <= header_next;
                pad_reg        <= pad_next;
                reply_reg      <= reply_next;
                received_reg   <= received_next;
                rejected_reg   <= rejected_next;
                out_valid_reg  <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_reg <= out_next;
        end
    end

endmodule
